[src/bfpc_pkg.sv]
// Package for the best-fit page claim table.
// Holds opcodes, status codes, field widths and the request struct; no dependencies.
package bfpc_pkg;

  localparam int unsigned PAGE_SLOTS_DEF = 64;
  localparam int unsigned OP_W = 3;
  localparam int unsigned TXN_W = 16;
  localparam int unsigned PAGE_W = 32;
  localparam int unsigned SPACE_W = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND = 3'd1;
  localparam logic [OP_W-1:0] OP_DONE = 3'd2;
  localparam logic [OP_W-1:0] OP_UPD_FREE = 3'd3;
  localparam logic [OP_W-1:0] OP_UPD_HELD = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Broadcast request seen by every cell.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [TXN_W-1:0] txn;
    logic [PAGE_W-1:0] page;
    logic [SPACE_W-1:0] space;
  } bfpc_req_t;

  // Per-cell match flags gathered by the top level.
  typedef struct packed {
    logic vld;
    logic page_hit;
    logic own_fit;
    logic free_fit;
    logic held_page_ok;
    logic free_page_ok;
  } bfpc_flags_t;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_COMMIT} bfpc_state_t;

endpackage

[src/bfpc_cell.sv]
// One table slot: stores a page entry and computes its match flags.
// Also runs one stage of the best-fit chain. Depends on bfpc_pkg.
module bfpc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  bfpc_pkg::bfpc_req_t           req,
  input  logic                          wr_add,
  input  logic                          wr_claim,
  input  logic                          wr_release,
  input  logic                          wr_space,
  input  logic                          best_in_vld,
  input  logic                          best_in_own,
  input  logic [bfpc_pkg::SPACE_W-1:0]  best_in_space,
  input  logic [bfpc_pkg::PAGE_W-1:0]   best_in_page,
  output logic                          best_out_vld,
  output logic                          best_out_own,
  output logic [bfpc_pkg::SPACE_W-1:0]  best_out_space,
  output logic [bfpc_pkg::PAGE_W-1:0]   best_out_page,
  output logic                          best_out_mine,
  output bfpc_pkg::bfpc_flags_t         flags
);
  import bfpc_pkg::*;

  logic vld;
  logic held;
  logic [TXN_W-1:0] owner;
  logic [PAGE_W-1:0] page;
  logic [SPACE_W-1:0] space;
  logic above;
  logic own_match;
  logic cand;
  logic better;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (wr_add) begin
      vld <= 1'b1;
    end
    if (wr_add) begin
      page <= req.page;
      space <= req.space;
      held <= 1'b0;
      owner <= '0;
    end else begin
      if (wr_claim) begin
        held <= 1'b1;
        owner <= req.txn;
      end else if (wr_release && own_match) begin
        held <= 1'b0;
        owner <= '0;
      end
      if (wr_space) begin
        space <= req.space;
      end
    end
  end

  assign own_match = vld && held && (owner == req.txn);
  assign above = (space > req.space) || ((space == req.space) && (page != '0));

  always_comb begin
    flags.vld = vld;
    flags.page_hit = vld && (page == req.page);
    flags.own_fit = own_match && above;
    flags.free_fit = vld && !held && above;
    flags.held_page_ok = flags.page_hit && own_match;
    flags.free_page_ok = flags.page_hit && !held;
  end

  // Chain stage: own-page candidates beat unowned ones; then smallest pair.
  assign cand = flags.own_fit || flags.free_fit;
  always_comb begin
    better = 1'b0;
    if (cand) begin
      if (!best_in_vld) begin
        better = 1'b1;
      end else if (flags.own_fit != best_in_own) begin
        better = flags.own_fit;
      end else begin
        better = (space < best_in_space) ||
                 ((space == best_in_space) && (page < best_in_page));
      end
    end
  end

  assign best_out_vld = best_in_vld || cand;
  assign best_out_own = better ? flags.own_fit : best_in_own;
  assign best_out_space = better ? space : best_in_space;
  assign best_out_page = better ? page : best_in_page;
  assign best_out_mine = better;

endmodule

[src/bfpc_chain.sv]
// Row of cells with a registered best-fit chain cut into segments.
// Depends on bfpc_pkg and bfpc_cell.
module bfpc_chain #(
  parameter int unsigned PAGE_SLOTS = bfpc_pkg::PAGE_SLOTS_DEF,
  parameter int unsigned SEG = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bfpc_pkg::bfpc_req_t                req,
  input  logic                               chain_go,
  input  logic [PAGE_SLOTS-1:0]              wr_add,
  input  logic                               claim_en,
  input  logic                               wr_release,
  input  logic [PAGE_SLOTS-1:0]              wr_space,
  output bfpc_pkg::bfpc_flags_t              flags [PAGE_SLOTS],
  output logic                               best_vld,
  output logic                               best_own,
  output logic [bfpc_pkg::SPACE_W-1:0]       best_space,
  output logic [bfpc_pkg::PAGE_W-1:0]        best_page,
  output logic [PAGE_SLOTS-1:0]              best_sel
);
  import bfpc_pkg::*;

  logic [PAGE_SLOTS:0] c_vld;
  logic [PAGE_SLOTS:0] c_own;
  logic [SPACE_W-1:0] c_space [PAGE_SLOTS+1];
  logic [PAGE_W-1:0] c_page [PAGE_SLOTS+1];
  logic [PAGE_SLOTS-1:0] mine;
  logic [PAGE_SLOTS-1:0] win;

  assign c_vld[0] = 1'b0;
  assign c_own[0] = 1'b0;
  assign c_space[0] = '0;
  assign c_page[0] = '0;

  // Registered hand-off every SEG cells.
  genvar g;
  generate
    for (g = 0; g < PAGE_SLOTS; g++) begin : g_cell
      logic in_vld;
      logic in_own;
      logic [SPACE_W-1:0] in_space;
      logic [PAGE_W-1:0] in_page;
      if ((g % SEG) == 0 && g != 0) begin : g_cut
        logic r_vld;
        logic r_own;
        logic [SPACE_W-1:0] r_space;
        logic [PAGE_W-1:0] r_page;
        always_ff @(posedge clk) begin
          r_vld <= c_vld[g];
          r_own <= c_own[g];
          r_space <= c_space[g];
          r_page <= c_page[g];
        end
        assign in_vld = r_vld;
        assign in_own = r_own;
        assign in_space = r_space;
        assign in_page = r_page;
      end else begin : g_pass
        assign in_vld = c_vld[g];
        assign in_own = c_own[g];
        assign in_space = c_space[g];
        assign in_page = c_page[g];
      end
      bfpc_cell u_cell (
        .clk(clk), .rst(rst), .req(req),
        .wr_add(wr_add[g]),
        .wr_claim(claim_en && best_sel[g]),
        .wr_release(wr_release),
        .wr_space(wr_space[g]),
        .best_in_vld(in_vld), .best_in_own(in_own),
        .best_in_space(in_space), .best_in_page(in_page),
        .best_out_vld(c_vld[g+1]), .best_out_own(c_own[g+1]),
        .best_out_space(c_space[g+1]), .best_out_page(c_page[g+1]),
        .best_out_mine(mine[g]),
        .flags(flags[g])
      );
    end
  endgenerate

  // The winner is the last cell that took over the chain; pages are unique so
  // match the final page number among valid entries.
  always_comb begin
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      win[i] = mine[i] && flags[i].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_go) begin
      best_vld <= c_vld[PAGE_SLOTS];
      best_own <= c_own[PAGE_SLOTS];
      best_space <= c_space[PAGE_SLOTS];
      best_page <= c_page[PAGE_SLOTS];
    end
  end

  generate
    for (g = 0; g < PAGE_SLOTS; g++) begin : g_sel
      always_ff @(posedge clk) begin
        if (chain_go) begin
          best_sel[g] <= win[g] &&
                         (c_page[g+1] == c_page[PAGE_SLOTS]) &&
                         (c_space[g+1] == c_space[PAGE_SLOTS]);
        end
      end
    end
  endgenerate

endmodule

[src/best_fit_page_claim_table_top.sv]
// Top level of the best-fit page claim table.
// Depends on bfpc_pkg and bfpc_chain (which holds the bfpc_cell row).
//
//  channel  | handshake        | beat contents
//  ---------+------------------+--------------------------------------
//  request  | start, busy      | opcode, txn_id, page_number, space
//  result   | done (strobe)    | status, chosen_page, chosen_space
//
// Each request passes through the scan, the commit cycle and the result cycle:
// the best-fit chain across the cell row is registered every eight cells,
// so the scan advances segment by segment, then the request commits, and
// in the result cycle busy is already low and the next beat can land.
// busy is high from the cycle after the accepted beat through commit.
// rst is synchronous and clears all valid bits; page data needs no reset.
// The result strobe lasts one cycle; the receiver cannot stall it.
module best_fit_page_claim_table_top #(
  parameter int unsigned PAGE_SLOTS = bfpc_pkg::PAGE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bfpc_pkg::OP_W-1:0]      opcode,
  input  logic [bfpc_pkg::TXN_W-1:0]     txn_id,
  input  logic [bfpc_pkg::PAGE_W-1:0]    page_number,
  input  logic [bfpc_pkg::SPACE_W-1:0]   space,
  output logic                           done,
  output logic [bfpc_pkg::STATUS_W-1:0]  status,
  output logic [bfpc_pkg::PAGE_W-1:0]    chosen_page,
  output logic [bfpc_pkg::SPACE_W-1:0]   chosen_space
);
  import bfpc_pkg::*;

  localparam int unsigned SEG = 8;
  localparam int unsigned NSEG = (PAGE_SLOTS + SEG - 1) / SEG;
  localparam int unsigned CW = $clog2(NSEG + 1);

  bfpc_state_t state, state_next;
  bfpc_req_t req;
  logic [CW-1:0] cnt;
  bfpc_flags_t flags [PAGE_SLOTS];
  logic [PAGE_SLOTS-1:0] wr_add, wr_space, free_first;
  logic best_vld, best_own;
  logic [SPACE_W-1:0] best_space;
  logic [PAGE_W-1:0] best_page;
  logic [PAGE_SLOTS-1:0] best_sel;
  logic any_hit, any_free, any_upd;
  logic commit, chain_go, claim_en, wr_release;

  // Capture the request beat and hold it for the whole scan.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.op <= opcode;
      req.txn <= txn_id;
      req.page <= page_number;
      req.space <= space;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_EVAL) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EVAL;
      S_EVAL: if (cnt == CW'(NSEG - 1)) state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    chain_go = 1'b0;
    commit = 1'b0;
    unique case (state)
      S_IDLE: busy = 1'b0;
      S_EVAL: chain_go = (cnt == CW'(NSEG - 1));
      S_COMMIT: commit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Flag reductions: lowest free slot, hits for add and updates.
  always_comb begin
    any_hit = 1'b0;
    any_free = 1'b0;
    any_upd = 1'b0;
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      free_first[i] = !flags[i].vld && !any_free;
      any_free = any_free || !flags[i].vld;
      any_hit = any_hit || flags[i].page_hit;
      wr_space[i] = commit &&
          (((req.op == OP_UPD_FREE) && flags[i].free_page_ok) ||
           ((req.op == OP_UPD_HELD) && flags[i].held_page_ok));
      any_upd = any_upd || wr_space[i];
    end
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      wr_add[i] = commit && (req.op == OP_ADD) && !any_hit && free_first[i];
    end
  end

  assign claim_en = commit && (req.op == OP_FIND) && best_vld && !best_own;
  assign wr_release = commit && (req.op == OP_DONE);

  bfpc_chain #(.PAGE_SLOTS(PAGE_SLOTS), .SEG(SEG)) u_chain (
    .clk(clk), .rst(rst), .req(req), .chain_go(chain_go),
    .wr_add(wr_add), .claim_en(claim_en), .wr_release(wr_release),
    .wr_space(wr_space), .flags(flags),
    .best_vld(best_vld), .best_own(best_own), .best_space(best_space),
    .best_page(best_page), .best_sel(best_sel)
  );

  // Drive the result beat for one cycle after commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= commit;
    end
    if (commit) begin
      chosen_page <= '0;
      chosen_space <= '0;
      case (req.op)
        OP_ADD: status <= any_hit ? ST_DUP : (any_free ? ST_OK : ST_FULL);
        OP_FIND: begin
          status <= best_vld ? ST_OK : ST_NONE;
          if (best_vld) begin
            chosen_page <= best_page;
            chosen_space <= best_space;
          end
        end
        OP_DONE: status <= ST_OK;
        OP_UPD_FREE, OP_UPD_HELD: status <= any_upd ? ST_OK : ST_NONE;
        default: status <= ST_NONE;
      endcase
    end
  end

endmodule

[tb/tb_best_fit_page_claim_table_top.sv]
// Testbench for best_fit_page_claim_table_top: directed table, then random beats.
// Depends on bfpc_pkg; predicts each result with a local copy of the page table.
module tb_best_fit_page_claim_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfpc_pkg::*;

  localparam int SLOTS = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [OP_W-1:0] OP_BAD = 3'd7;
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;

  logic clk, rst, start, busy, done;
  logic [OP_W-1:0] opcode;
  logic [TXN_W-1:0] txn_id;
  logic [PAGE_W-1:0] page_number;
  logic [SPACE_W-1:0] space;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0] chosen_page;
  logic [SPACE_W-1:0] chosen_space;

  best_fit_page_claim_table_top dut (.*);

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [PAGE_W-1:0] pg;
    logic [SPACE_W-1:0] sp;
  } claim_res_t;

  // Mirror of the page table.
  bit tbl_vld[SLOTS];
  logic [PAGE_W-1:0] tbl_pg[SLOTS];
  logic [SPACE_W-1:0] tbl_sp[SLOTS];
  bit tbl_held[SLOTS];
  logic [TXN_W-1:0] tbl_own[SLOTS];

  claim_res_t pending_claims[$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int locate_page(logic [PAGE_W-1:0] p);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_vld[i] && tbl_pg[i] == p) return i;
    return -1;
  endfunction

  // Smallest (space, page) strictly above (want, 0) in the chosen pool.
  function automatic int best_slot(bit own, logic [TXN_W-1:0] t, logic [SPACE_W-1:0] want);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_vld[i]) continue;
      if (own ? (!tbl_held[i] || tbl_own[i] != t) : tbl_held[i]) continue;
      if (!(tbl_sp[i] > want || (tbl_sp[i] == want && tbl_pg[i] != 0))) continue;
      if (b < 0 || tbl_sp[i] < tbl_sp[b] || (tbl_sp[i] == tbl_sp[b] && tbl_pg[i] < tbl_pg[b]))
        b = i;
    end
    return b;
  endfunction

  function automatic claim_res_t predict_claim(logic [OP_W-1:0] op, logic [TXN_W-1:0] t,
                                               logic [PAGE_W-1:0] p, logic [SPACE_W-1:0] s);
    claim_res_t r;
    int i;
    r = '{st: ST_NONE, pg: '0, sp: '0};
    case (op)
      OP_ADD: begin
        if (locate_page(p) >= 0) r.st = ST_DUP;
        else begin
          r.st = ST_FULL;
          for (int k = 0; k < SLOTS; k++)
            if (!tbl_vld[k]) begin
              tbl_vld[k] = 1; tbl_pg[k] = p; tbl_sp[k] = s;
              tbl_held[k] = 0; tbl_own[k] = '0; r.st = ST_OK;
              break;
            end
        end
      end
      OP_FIND: begin
        i = best_slot(1, t, s);
        if (i < 0) begin
          i = best_slot(0, t, s);
          if (i >= 0) begin
            tbl_held[i] = 1; tbl_own[i] = t;
          end
        end
        if (i >= 0) r = '{st: ST_OK, pg: tbl_pg[i], sp: tbl_sp[i]};
      end
      OP_DONE: begin
        for (int k = 0; k < SLOTS; k++)
          if (tbl_vld[k] && tbl_held[k] && tbl_own[k] == t) begin
            tbl_held[k] = 0; tbl_own[k] = '0;
          end
        r.st = ST_OK;
      end
      OP_UPD_FREE: begin
        i = locate_page(p);
        if (i >= 0 && !tbl_held[i]) begin
          tbl_sp[i] = s; r.st = ST_OK;
        end
      end
      OP_UPD_HELD: begin
        i = locate_page(p);
        if (i >= 0 && tbl_held[i] && tbl_own[i] == t) begin
          tbl_sp[i] = s; r.st = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Check each result strobe against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_claims.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        claim_res_t e;
        e = pending_claims.pop_front();
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (chosen_page !== e.pg) begin
          $error("chosen_page exp %0h got %0h", e.pg, chosen_page); errors++;
        end
        if (chosen_space !== e.sp) begin
          $error("chosen_space exp %0h got %0h", e.sp, chosen_space); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one beat: hold start until accepted, then drop it unless the next
  // beat follows at once. The expectation is queued at the accepting edge.
  task automatic send_beat(logic [OP_W-1:0] op, logic [TXN_W-1:0] t,
                           logic [PAGE_W-1:0] p, logic [SPACE_W-1:0] s,
                           bit known, claim_res_t kexp);
    claim_res_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; opcode <= op; txn_id <= t; page_number <= p; space <= s;
    do @(posedge clk); while (busy);
    r = predict_claim(op, t, p, s);
    if (known && r != kexp) begin
      $error("table row disagrees with predictor: status %0d vs %0d", kexp.st, r.st);
      errors++;
    end
    pending_claims.push_back(r);
  endtask

  typedef struct {
    logic [OP_W-1:0] op;
    logic [TXN_W-1:0] t;
    logic [PAGE_W-1:0] p;
    logic [SPACE_W-1:0] s;
    bit known;
    claim_res_t r;
  } stim_row_t;

  // Pages drawn from a small pool so that duplicates and updates hit.
  function automatic logic [PAGE_W-1:0] pick_page();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? '0 : '1;
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic logic [SPACE_W-1:0] pick_space();
    case ($urandom_range(5))
      0: return SPACE_W'($urandom());
      1: return $urandom_range(1) ? '0 : '1;
      default: return SPACE_W'($urandom_range(300));
    endcase
  endfunction

  function automatic logic [TXN_W-1:0] pick_txn();
    return $urandom_range(7) == 0 ? TXN_W'($urandom()) : TXN_W'($urandom_range(3));
  endfunction

  initial begin
    stim_row_t rows[$];
    logic [OP_W-1:0] op;
    int n;
    claim_res_t z;
    z = '{st: ST_OK, pg: '0, sp: '0};
    // Directed rows: empty table, extremes, duplicate, claims, updates, release, bad ops.
    rows = '{
      '{OP_FIND, 16'h0, 32'h0, 16'h0, 1, '{ST_NONE, 32'h0, 16'h0}},
      '{OP_DONE, 16'hFFFF, 32'h0, 16'h0, 1, z},
      '{OP_UPD_FREE, 16'h0, 32'hFFFFFFFF, 16'h1, 1, '{ST_NONE, 32'h0, 16'h0}},
      '{OP_ADD, 16'h0, 32'h0, 16'h0, 1, z},
      '{OP_ADD, 16'h0, 32'hFFFFFFFF, 16'hFFFF, 1, z},
      '{OP_ADD, 16'h0, 32'h0, 16'h5, 1, '{ST_DUP, 32'h0, 16'h0}},
      '{OP_ADD, 16'h0, 32'h10, 16'h64, 1, z},
      '{OP_ADD, 16'h0, 32'h11, 16'h64, 0, z},
      '{OP_FIND, 16'h0, 32'h0, 16'h0, 0, z},
      '{OP_FIND, 16'h1, 32'h0, 16'h64, 0, z},
      '{OP_FIND, 16'h1, 32'h0, 16'h10, 0, z},
      '{OP_FIND, 16'h2, 32'h0, 16'hFFFF, 1, '{ST_OK, 32'hFFFFFFFF, 16'hFFFF}},
      '{OP_UPD_HELD, 16'h2, 32'h11, 16'h1, 0, z},
      '{OP_UPD_HELD, 16'h1, 32'h11, 16'hFFFF, 0, z},
      '{OP_UPD_FREE, 16'h0, 32'h0, 16'hFFFF, 0, z},
      '{OP_FIND, 16'hFFFF, 32'h0, 16'hFFFE, 0, z},
      '{OP_DONE, 16'h1, 32'h0, 16'h0, 1, z},
      '{OP_UPD_FREE, 16'h0, 32'h11, 16'h0, 0, z},
      '{OP_BAD, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, '{ST_NONE, 32'h0, 16'h0}},
      '{OP_BAD_LO, 16'h0, 32'h0, 16'h0, 1, '{ST_NONE, 32'h0, 16'h0}}
    };
    start = 0; opcode = '0; txn_id = '0; page_number = '0; space = '0;
    rst = 1;
    for (int k = 0; k < SLOTS; k++) tbl_vld[k] = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[k])
      send_beat(rows[k].op, rows[k].t, rows[k].p, rows[k].s, rows[k].known, rows[k].r);
    // Fill the table to hit the full status, then release txns 16'hFFFF and 16'h1.
    for (int k = 0; k < SLOTS; k++)
      send_beat(OP_ADD, '0, 32'h1000 + k, 16'($urandom()), 0, z);
    send_beat(OP_DONE, 16'hFFFF, '0, '0, 0, z);
    send_beat(OP_DONE, 16'h1, '0, '0, 0, z);
    // Random phases: no idling, sender idle 78%, then 35%, then 78% again.
    // Table stays full here, so random adds mostly see duplicate or full;
    // that is fine for finds and updates but reset-free refilling is not needed.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 0) ? 0 : (ph == 2) ? 35 : 78;
      n = (ph == 1) ? 300 : 430;
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(9))
          0, 1: op = OP_ADD;
          2, 3, 4: op = OP_FIND;
          5: op = OP_DONE;
          6: op = OP_UPD_FREE;
          7, 8: op = OP_UPD_HELD;
          default: op = OP_W'($urandom_range(7));
        endcase
        send_beat(op, pick_txn(), pick_page(), pick_space(), 0, z);
      end
    end
    start <= 0;
    wait (pending_claims.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
